// File: hw/rtl/vibration_magnitude_hysteresis_detector_top_assert.svh
// Assertion macros shared by the detector's checker.
`ifndef VIBRATION_MAGNITUDE_HYSTERESIS_DETECTOR_TOP_ASSERT_SVH
`define VIBRATION_MAGNITUDE_HYSTERESIS_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define VMHD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define VMHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/vmhd_pkg.sv
// Types and constants of the vibration magnitude detector.
package vmhd_pkg;

	typedef logic [1:0] cfg_addr_t;

	localparam cfg_addr_t REG_MG_PER_COUNT     = 2'd0;
	localparam cfg_addr_t REG_SMOOTHING_ALPHA  = 2'd1;
	localparam cfg_addr_t REG_ON_THRESHOLD_MG  = 2'd2;
	localparam cfg_addr_t REG_OFF_THRESHOLD_MG = 2'd3;

	localparam int CFG_DATA_W = 17;

	localparam logic [15:0] MG_PER_COUNT_RST     = 16'd7995;
	localparam logic [16:0] SMOOTHING_ALPHA_RST  = 17'd19661;
	localparam logic [15:0] ON_THRESHOLD_MG_RST  = 16'd300;
	localparam logic [15:0] OFF_THRESHOLD_MG_RST = 16'd200;

	localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S24_MIN = 24'sh800000;

	// digits of the root of the 48-bit sum of squares
	localparam int ROOT_STEPS = 24;

	typedef struct packed {
		logic [15:0] mg_per_count;
		logic [16:0] smoothing_alpha;
		logic [15:0] on_threshold_mg;
		logic [15:0] off_threshold_mg;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_t;

	typedef struct packed {
		logic signed [23:0] smooth_x;
		logic signed [23:0] smooth_y;
		logic signed [23:0] smooth_z;
		logic        [23:0] magnitude;
		logic               event_active;
		logic               event_began;
		logic               event_ended;
	} out_t;

	// queue entry: filtered axes and their sum of squares
	typedef struct packed {
		logic signed [23:0] smooth_x;
		logic signed [23:0] smooth_y;
		logic signed [23:0] smooth_z;
		logic        [47:0] sumsq;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hw/rtl/vmhd_queue.sv
// Small FIFO between the filter front end and the root back end.
module vmhd_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vmhd_pkg::qent_t  push_data,
	input  logic             pop,
	output vmhd_pkg::qent_t  pop_data,
	output vmhd_pkg::q_stat_t stat
);
	import vmhd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/vmhd_front.sv
// Front end: takes a sample, scales and smooths each axis, sums the squares.
module vmhd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vmhd_pkg::in_t     in_data,
	input  vmhd_pkg::cfg_t    cfg,
	output logic              push,
	output vmhd_pkg::qent_t   push_data,
	input  vmhd_pkg::q_stat_t q_stat
);
	import vmhd_pkg::*;

	typedef enum logic [6:0] {
		F_IDLE      = 7'b0000001,
		F_MUL_SCALE = 7'b0000010,
		F_MUL_ALPHA = 7'b0000100,
		F_UPDATE    = 7'b0001000,
		F_SQUARE    = 7'b0010000,
		F_ACCUM     = 7'b0100000,
		F_PUSH      = 7'b1000000
	} front_state_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	front_state_t       state_q;
	logic [1:0]         axis_q;
	in_t                in_q;
	logic signed [51:0] prod_q;
	logic [47:0]        sum_q;
	logic signed [23:0] f_q [3];

	logic signed [15:0] raw_sel;
	logic signed [23:0] f_cur;
	logic signed [24:0] x_scaled;
	logic signed [25:0] diff;
	logic signed [26:0] step_v;
	logic signed [27:0] upd;
	logic signed [23:0] f_new;
	logic signed [26:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [51:0] prod;

	always_comb begin
		case (axis_q)
			AXIS_X:  raw_sel = in_q.accel_x;
			AXIS_Y:  raw_sel = in_q.accel_y;
			default: raw_sel = in_q.accel_z;
		endcase
	end

	assign f_cur    = f_q[axis_q];
	// scaled axis is the count times sensitivity, floor-shifted by 8
	assign x_scaled = prod_q[32:8];
	assign diff     = 26'(x_scaled) - 26'(f_cur);
	assign step_v   = prod_q[42:16];
	assign upd      = 28'(f_cur) + 28'(step_v);

	always_comb begin
		if (upd[27:23] == 5'b00000 || upd[27:23] == 5'b11111) begin
			f_new = upd[23:0];
		end else if (upd[27]) begin
			f_new = S24_MIN;
		end else begin
			f_new = S24_MAX;
		end
	end

	// one shared multiplier, operands picked by step
	always_comb begin
		case (state_q)
			F_MUL_SCALE: begin
				mul_a = 27'(raw_sel);
				mul_b = $signed({9'd0, cfg.mg_per_count});
			end
			F_MUL_ALPHA: begin
				mul_a = 27'(diff);
				mul_b = $signed({8'd0, cfg.smoothing_alpha});
			end
			default: begin
				mul_a = 27'(f_cur);
				mul_b = 25'(f_cur);
			end
		endcase
	end

	assign prod = 52'(mul_a) * 52'(mul_b);

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_stat.full;

	assign push_data.smooth_x = f_q[0];
	assign push_data.smooth_y = f_q[1];
	assign push_data.smooth_z = f_q[2];
	assign push_data.sumsq    = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= AXIS_X;
			f_q[0]  <= '0;
			f_q[1]  <= '0;
			f_q[2]  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						axis_q  <= AXIS_X;
						state_q <= F_MUL_SCALE;
					end
				end
				F_MUL_SCALE: state_q <= F_MUL_ALPHA;
				F_MUL_ALPHA: state_q <= F_UPDATE;
				F_UPDATE: begin
					f_q[axis_q] <= f_new;
					state_q     <= F_SQUARE;
				end
				F_SQUARE: state_q <= F_ACCUM;
				F_ACCUM: begin
					if (axis_q == AXIS_Z) begin
						state_q <= F_PUSH;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= F_MUL_SCALE;
					end
				end
				F_PUSH: begin
					if (!q_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			in_q  <= in_data;
			sum_q <= '0;
		end
		if (state_q == F_MUL_SCALE || state_q == F_MUL_ALPHA || state_q == F_SQUARE) begin
			prod_q <= prod;
		end
		if (state_q == F_ACCUM) begin
			sum_q <= sum_q + prod_q[47:0];
		end
	end

endmodule

// File: hw/rtl/vmhd_back.sv
// Back end: digit-serial square root, hysteresis flag and output register.
module vmhd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  vmhd_pkg::qent_t   pop_data,
	input  vmhd_pkg::q_stat_t q_stat,
	output logic              pop,
	input  vmhd_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output vmhd_pkg::out_t    out_data
);
	import vmhd_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_ROOT = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [4:0]         cnt_q;
	logic [47:0]        rad_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [23:0] sx_q;
	logic signed [23:0] sy_q;
	logic signed [23:0] sz_q;
	logic               flag_q;
	logic               out_valid_q;
	out_t               out_q;

	logic [27:0] rem_sh;
	logic [27:0] trial;
	logic        fits;
	logic [23:0] on_lim;
	logic [23:0] off_lim;
	logic        began;
	logic        mid;
	logic        ended;
	logic        emit;

	// restoring root: bring down two bits, try (root << 2) | 1
	assign rem_sh = {rem_q, rad_q[47:46]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	assign on_lim  = {cfg.on_threshold_mg, 8'h00};
	assign off_lim = {cfg.off_threshold_mg, 8'h00};
	assign began   = !flag_q && (root_q > on_lim);
	assign mid     = flag_q || began;
	assign ended   = mid && (root_q < off_lim);

	assign pop       = (state_q == B_IDLE) && !q_stat.empty;
	assign emit      = (state_q == B_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						cnt_q   <= '0;
						state_q <= B_ROOT;
					end
				end
				B_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(ROOT_STEPS - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (emit) begin
				flag_q      <= mid && !ended;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rad_q  <= pop_data.sumsq;
			rem_q  <= '0;
			root_q <= '0;
			sx_q   <= pop_data.smooth_x;
			sy_q   <= pop_data.smooth_y;
			sz_q   <= pop_data.smooth_z;
		end
		if (state_q == B_ROOT) begin
			rad_q <= {rad_q[45:0], 2'b00};
			if (fits) begin
				rem_q  <= 26'(rem_sh - trial);
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[25:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end
		if (emit) begin
			out_q.smooth_x     <= sx_q;
			out_q.smooth_y     <= sy_q;
			out_q.smooth_z     <= sz_q;
			out_q.magnitude    <= root_q;
			out_q.event_active <= mid && !ended;
			out_q.event_began  <= began;
			out_q.event_ended  <= ended;
		end
	end

endmodule

// File: hw/rtl/vibration_magnitude_hysteresis_detector_top.sv
// Top level of the vibration magnitude detector with hysteresis.
//
// Input channel (in_valid/in_ready/in_data): one request carries a raw
// three-axis accelerometer sample. Output channel (out_valid/out_ready/
// out_data): one request per sample with the smoothed axes, the magnitude in
// Q8 milli-g, the hysteresis flag and its set/clear edges.
// Config port: cfg_we/cfg_addr/cfg_wdata, single-cycle writes, no read-back;
// write only while the block is idle.
//
// Flow: the front end takes a sample and runs five steps per axis on one
// shared multiplier, then pushes the result into the queue; the back end
// pops it, computes 24 root digits and writes the output register. The
// front end can take a new sample while the back end is still busy with the
// last one; the square-root digit loop sets the sustained rate.
//
// Reset: filters and flag cleared, registers at their defaults, queue and
// output register empty. If the receiver stalls, the result sits in the
// output register, the back end parks with the next result, the queue
// fills and then in_ready stays low until space frees up.
module vibration_magnitude_hysteresis_detector_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vmhd_pkg::in_t        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vmhd_pkg::out_t       out_data,
	input  logic                 cfg_we,
	input  vmhd_pkg::cfg_addr_t  cfg_addr,
	input  logic [16:0]          cfg_wdata
);
	import vmhd_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	qent_t   push_data;
	logic    pop;
	qent_t   pop_data;
	q_stat_t q_stat;

	// register file; unknown indexes cannot occur with a two-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mg_per_count     <= MG_PER_COUNT_RST;
			cfg_q.smoothing_alpha  <= SMOOTHING_ALPHA_RST;
			cfg_q.on_threshold_mg  <= ON_THRESHOLD_MG_RST;
			cfg_q.off_threshold_mg <= OFF_THRESHOLD_MG_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MG_PER_COUNT:     cfg_q.mg_per_count     <= cfg_wdata[15:0];
				REG_SMOOTHING_ALPHA:  cfg_q.smoothing_alpha  <= cfg_wdata[CFG_DATA_W-1:0];
				REG_ON_THRESHOLD_MG:  cfg_q.on_threshold_mg  <= cfg_wdata[15:0];
				REG_OFF_THRESHOLD_MG: cfg_q.off_threshold_mg <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// scale, smooth and square each axis
	vmhd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	// decouples the two halves so each stalls on its own
	vmhd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// magnitude root, hysteresis and the output register
	vmhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.q_stat    (q_stat),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hw/rtl/vmhd_checker.sv
// Port-level checks of the detector's output channel, bound to the top level.
`include "vibration_magnitude_hysteresis_detector_top_assert.svh"

module vmhd_port_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input vmhd_pkg::out_t out_data
);
	import vmhd_pkg::*;

	`VMHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`VMHD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
	`VMHD_ASSERT_NOW(a_end_clears, out_valid && out_data.event_ended, !out_data.event_active, "flag still set after clear edge")
	`VMHD_ASSERT_NOW(a_begin_sets, out_valid && out_data.event_began && !out_data.event_ended, out_data.event_active, "flag not set after set edge")

endmodule

bind vibration_magnitude_hysteresis_detector_top vmhd_port_checker u_vmhd_checker (.*);
